// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the matcher sources
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every edge out of reset
`define WBPM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// antecedent at one edge implies consequent at the next
`define WBPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define WBPM_ASSERT(lbl, clk, rst, prop)
`define WBPM_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== src/wbpm_pkg.sv =====
// ----------------------------------------------------------------------------
// wbpm_pkg
// types and constants of the wildcard byte pattern matcher
// ----------------------------------------------------------------------------
package wbpm_pkg;

  localparam int BYTE_W     = 8;
  localparam int ADDR_W     = 48;
  localparam int REG_POS    = 32;   // pattern positions held by the registers
  localparam int POS_W      = 5;    // index of one of those positions
  localparam int LEN_W      = 6;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WILD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEN   = 3'd5;

  // per-cell view of the pattern, aligned to the cell's distance back
  typedef struct packed {
    logic              in_use;
    logic              wild;
    logic [BYTE_W-1:0] pat;
  } cell_cfg_t;

endpackage

// ===== src/wbpm_if.sv =====
// ----------------------------------------------------------------------------
// wbpm_if
// valid/ready channels of the matcher: byte items in, match items out
// ----------------------------------------------------------------------------
interface wbpm_in_if;
  logic                         valid;
  logic                         ready;
  logic [wbpm_pkg::BYTE_W-1:0]  data_byte;
  logic [wbpm_pkg::ADDR_W-1:0]  byte_address;
  logic                         block_start;

  modport source (output valid, output data_byte, output byte_address,
                  output block_start, input ready);
  modport sink (input valid, input data_byte, input byte_address,
                input block_start, output ready);
endinterface

interface wbpm_out_if;
  logic                         valid;
  logic                         ready;
  logic [wbpm_pkg::ADDR_W-1:0]  match_address;

  modport source (output valid, output match_address, input ready);
  modport sink (input valid, input match_address, output ready);
endinterface

// ===== src/wbpm_cell.sv =====
// ----------------------------------------------------------------------------
// wbpm_cell
// one history byte of the window, with its compare against the pattern
// ----------------------------------------------------------------------------
module wbpm_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         shift_en,
  input  logic [wbpm_pkg::BYTE_W-1:0]  byte_in,
  input  logic                         valid_in,
  input  logic                         block_start,
  input  wbpm_pkg::cell_cfg_t          cfg,
  output logic [wbpm_pkg::BYTE_W-1:0]  byte_out,
  output logic                         valid_out,
  output logic                         ok
);

  logic [wbpm_pkg::BYTE_W-1:0] byte_q;
  logic                        valid_q;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_q <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (shift_en) begin
      valid_q <= valid_in;
    end
  end

  // a block start drops all history, so an in-use cell then fails
  assign ok = !cfg.in_use ||
              (valid_q && !block_start && (cfg.wild || (byte_q == cfg.pat)));

  assign byte_out  = byte_q;
  assign valid_out = valid_q;

endmodule

// ===== src/wbpm_out_buf.sv =====
// ----------------------------------------------------------------------------
// wbpm_out_buf
// two-entry output buffer that parts the match side from the consumer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wbpm_out_buf (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [wbpm_pkg::ADDR_W-1:0]  push_data,
  output logic                         has_room,
  wbpm_out_if.source                   out_ch
);

  logic [wbpm_pkg::ADDR_W-1:0] slot0;
  logic [wbpm_pkg::ADDR_W-1:0] slot1;
  logic [1:0]                  count;
  logic [1:0]                  count_next;
  logic                        pop;

  assign pop      = out_ch.valid && out_ch.ready;
  assign has_room = (count != 2'd2);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end else if (pop && !push) begin
      slot0 <= slot1;
    end else if (push && pop) begin
      if (count == 2'd1) begin
        slot0 <= push_data;
      end else begin
        slot0 <= slot1;
        slot1 <= push_data;
      end
    end
  end

  assign out_ch.valid         = (count != 2'd0);
  assign out_ch.match_address = slot0;

  `WBPM_ASSERT(a_count_range, clk, rst, count != 2'd3)
  `WBPM_ASSERT(a_no_push_full, clk, rst, !(push && count == 2'd2))
  `WBPM_ASSERT_NEXT(a_pop_drains, clk, rst, pop && !push, count == $past(count) - 2'd1)
  `WBPM_ASSERT_NEXT(a_head_holds, clk, rst, out_ch.valid && !out_ch.ready,
                    out_ch.valid && $stable(out_ch.match_address))

endmodule

// ===== src/wildcard_byte_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_matcher
// streaming search for a wildcard byte pattern over scanned memory
// ----------------------------------------------------------------------------
// Takes one memory byte item per clock cycle while input ready is high, and
// reports the start address of every alignment where the configured pattern
// (up to 32 positions, wildcard positions match any byte) ends on that byte,
// overlapping matches included; history is dropped at each block start, so no
// match spans blocks. The byte history is a row of PATTERN_MAX-1 cells that
// shift one step per accepted item; each cell compares its byte against the
// pattern position that lies at its distance back, and the cell results are
// and-ed with the compare of the present byte in the accept cycle. A found
// match is pushed into a two-entry output buffer when its byte is accepted;
// input ready drops only while both entries wait. Pattern registers sit on a
// 64-bit APB port at byte address 8*i; a write takes effect for the next item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wildcard_byte_pattern_matcher #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  wbpm_in_if.sink                             in_ch,
  wbpm_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wbpm_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [wbpm_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [wbpm_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  // history cells and the longest usable pattern
  localparam int CELLS   = PATTERN_MAX - 1;
  localparam int MAX_LEN = (PATTERN_MAX < wbpm_pkg::REG_POS) ? PATTERN_MAX
                                                             : wbpm_pkg::REG_POS;
  localparam int DIST_W  = 7;   // holds any cell distance and length

  // configuration registers
  logic [wbpm_pkg::CFG_DATA_W-1:0] pat_reg [4];
  logic [wbpm_pkg::REG_POS-1:0]    wild_mask;
  logic [wbpm_pkg::LEN_W-1:0]      pat_len;
  logic [wbpm_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic                            cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[wbpm_pkg::CFG_ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_reg[0] <= '0;
      pat_reg[1] <= '0;
      pat_reg[2] <= '0;
      pat_reg[3] <= '0;
      wild_mask  <= '0;
      pat_len    <= wbpm_pkg::LEN_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        wbpm_pkg::REG_PAT_0: pat_reg[0] <= pwdata;
        wbpm_pkg::REG_PAT_1: pat_reg[1] <= pwdata;
        wbpm_pkg::REG_PAT_2: pat_reg[2] <= pwdata;
        wbpm_pkg::REG_PAT_3: pat_reg[3] <= pwdata;
        wbpm_pkg::REG_WILD:  wild_mask  <= pwdata[wbpm_pkg::REG_POS-1:0];
        wbpm_pkg::REG_LEN:   pat_len    <= pwdata[wbpm_pkg::LEN_W-1:0];
        default: begin
          // addresses past the register list are ignored
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      wbpm_pkg::REG_PAT_0: prdata = pat_reg[0];
      wbpm_pkg::REG_PAT_1: prdata = pat_reg[1];
      wbpm_pkg::REG_PAT_2: prdata = pat_reg[2];
      wbpm_pkg::REG_PAT_3: prdata = pat_reg[3];
      wbpm_pkg::REG_WILD:  prdata = {{(wbpm_pkg::CFG_DATA_W-wbpm_pkg::REG_POS){1'b0}},
                                     wild_mask};
      wbpm_pkg::REG_LEN:   prdata = {{(wbpm_pkg::CFG_DATA_W-wbpm_pkg::LEN_W){1'b0}},
                                     pat_len};
      default:             prdata = '0;
    endcase
  end

  // effective length: zero acts as one, clamp to the usable maximum
  logic [wbpm_pkg::LEN_W-1:0] eff_len;

  always_comb begin
    priority if (pat_len == '0) begin
      eff_len = wbpm_pkg::LEN_W'(1);
    end else if (pat_len > wbpm_pkg::LEN_W'(MAX_LEN)) begin
      eff_len = wbpm_pkg::LEN_W'(MAX_LEN);
    end else begin
      eff_len = pat_len;
    end
  end

  // pattern positions flattened, position k in bits 8k up to 8k+7
  logic [wbpm_pkg::REG_POS*wbpm_pkg::BYTE_W-1:0] pat_flat;
  assign pat_flat = {pat_reg[3], pat_reg[2], pat_reg[1], pat_reg[0]};

  // accept and output side
  logic                        accept;
  logic                        has_room;
  logic                        hit;
  logic [wbpm_pkg::ADDR_W-1:0] start_addr;

  assign in_ch.ready = has_room;
  assign accept      = in_ch.valid && in_ch.ready;

  // present byte closes the match at position eff_len-1
  logic [wbpm_pkg::POS_W-1:0] last_pos;
  logic                       cur_ok;

  assign last_pos = wbpm_pkg::POS_W'(eff_len - wbpm_pkg::LEN_W'(1));
  assign cur_ok   = wild_mask[last_pos] ||
                    (in_ch.data_byte == pat_flat[last_pos*wbpm_pkg::BYTE_W +: wbpm_pkg::BYTE_W]);

  // row of history cells, cell j holds the byte j+1 items back
  logic [wbpm_pkg::BYTE_W-1:0] cell_byte  [CELLS];
  logic [CELLS-1:0]            cell_valid;
  logic [CELLS-1:0]            cell_ok;

  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    wbpm_pkg::cell_cfg_t          ccfg;
    logic [DIST_W-1:0]            pos_diff;
    logic [wbpm_pkg::POS_W-1:0]   pos;
    logic [wbpm_pkg::BYTE_W-1:0]  byte_in;
    logic                         valid_in;

    // pattern position for this distance is eff_len-2-j
    assign pos_diff = DIST_W'(eff_len) - DIST_W'(2) - DIST_W'(j);
    assign pos      = pos_diff[wbpm_pkg::POS_W-1:0];

    always_comb begin
      ccfg.in_use = (DIST_W'(eff_len) > DIST_W'(j + 1));
      ccfg.wild   = wild_mask[pos];
      ccfg.pat    = pat_flat[pos*wbpm_pkg::BYTE_W +: wbpm_pkg::BYTE_W];
    end

    if (j == 0) begin : g_head
      assign byte_in  = in_ch.data_byte;
      assign valid_in = 1'b1;
    end else begin : g_body
      // a block start empties the history behind the new byte
      assign byte_in  = cell_byte[j-1];
      assign valid_in = cell_valid[j-1] && !in_ch.block_start;
    end

    wbpm_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .shift_en    (accept),
      .byte_in     (byte_in),
      .valid_in    (valid_in),
      .block_start (in_ch.block_start),
      .cfg         (ccfg),
      .byte_out    (cell_byte[j]),
      .valid_out   (cell_valid[j]),
      .ok          (cell_ok[j])
    );
  end

  assign hit        = cur_ok && (&cell_ok);
  assign start_addr = in_ch.byte_address - wbpm_pkg::ADDR_W'(eff_len - wbpm_pkg::LEN_W'(1));

  wbpm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && hit),
    .push_data (start_addr),
    .has_room  (has_room),
    .out_ch    (out_ch)
  );

  // the newest cell is always filled after an item
  `WBPM_ASSERT_NEXT(a_head_filled, clk, rst, accept, cell_valid[0])
  // history moves only with accepted items
  `WBPM_ASSERT_NEXT(a_hist_idle, clk, rst, !accept, $stable(cell_valid))
  // a block start leaves no history, so only single-byte patterns can hit
  `WBPM_ASSERT(a_start_no_hist, clk, rst,
               !(accept && in_ch.block_start && hit && eff_len != wbpm_pkg::LEN_W'(1)))

endmodule

// ===== tb/match_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// match_checker
// watches the byte, match and register channels and checks every match item
// ----------------------------------------------------------------------------
// Keeps its own copy of the pattern registers from the write traffic, replays
// each accepted byte item through a window search to get the expected match
// address, and compares each accepted match item with the oldest one waiting.
// ----------------------------------------------------------------------------
module match_checker #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  wbpm_in_if                              in_mon,
  wbpm_out_if                             out_mon,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [wbpm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [wbpm_pkg::CFG_DATA_W-1:0] pwdata,
  output int                              errors,
  output int                              outstanding
);

  logic [wbpm_pkg::CFG_DATA_W-1:0] pat_reg [4];
  logic [wbpm_pkg::REG_POS-1:0]    wild_reg;
  logic [wbpm_pkg::LEN_W-1:0]      len_reg;
  logic [wbpm_pkg::BYTE_W-1:0]     history [PATTERN_MAX-1];
  int                              fill;
  logic [wbpm_pkg::ADDR_W-1:0]     match_q [$];
  int                              mismatch_count = 0;

  assign errors = mismatch_count;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t: match check error: %s", $time, what);
  endtask

  // one byte through the window search; queues the start address of a hit
  task automatic scan_byte(input logic [wbpm_pkg::BYTE_W-1:0] data,
                           input logic [wbpm_pkg::ADDR_W-1:0] addr,
                           input logic start);
    int                                m;
    int                                k;
    logic                              hit;
    logic [wbpm_pkg::BYTE_W-1:0]       b;
    logic [4*wbpm_pkg::CFG_DATA_W-1:0] pat_flat;
    m = len_reg;
    if (m < 1) m = 1;
    if (m > PATTERN_MAX) m = PATTERN_MAX;
    if (m > wbpm_pkg::REG_POS) m = wbpm_pkg::REG_POS;
    if (start) fill = 0;
    pat_flat = {pat_reg[3], pat_reg[2], pat_reg[1], pat_reg[0]};
    hit = (fill >= m - 1);
    for (k = 0; k < m; k++) begin
      if (!wild_reg[k]) begin
        b = (k == m - 1) ? data : history[m - 2 - k];
        if (b != pat_flat[k*wbpm_pkg::BYTE_W +: wbpm_pkg::BYTE_W]) hit = 1'b0;
      end
    end
    if (hit) match_q.insert(match_q.size(), addr - wbpm_pkg::ADDR_W'(m - 1));
    for (k = PATTERN_MAX - 2; k > 0; k--) history[k] = history[k-1];
    history[0] = data;
    if (fill < PATTERN_MAX - 1) fill++;
  endtask

  always @(posedge clk) begin : monitor
    logic [wbpm_pkg::ADDR_W-1:0] want;
    int                          i;
    if (rst) begin
      for (i = 0; i < 4; i++) pat_reg[i] = '0;
      wild_reg = '0;
      len_reg  = wbpm_pkg::LEN_W'(1);
      for (i = 0; i < PATTERN_MAX - 1; i++) history[i] = '0;
      fill = 0;
      match_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        scan_byte(in_mon.data_byte, in_mon.byte_address, in_mon.block_start);
      if (out_mon.valid && out_mon.ready) begin
        if (match_q.size() == 0) begin
          report_mismatch($sformatf("unexpected match at %h", out_mon.match_address));
        end else begin
          want = match_q.pop_front();
          if (out_mon.match_address !== want)
            report_mismatch($sformatf("match_address %h, expected %h",
                                      out_mon.match_address, want));
        end
      end
      if (psel && penable && pwrite && pready) begin
        unique case (paddr[wbpm_pkg::CFG_ADDR_W-1:3])
          wbpm_pkg::REG_PAT_0: pat_reg[0] = pwdata;
          wbpm_pkg::REG_PAT_1: pat_reg[1] = pwdata;
          wbpm_pkg::REG_PAT_2: pat_reg[2] = pwdata;
          wbpm_pkg::REG_PAT_3: pat_reg[3] = pwdata;
          wbpm_pkg::REG_WILD:  wild_reg = pwdata[wbpm_pkg::REG_POS-1:0];
          wbpm_pkg::REG_LEN:   len_reg = pwdata[wbpm_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding = match_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the wildcard byte pattern matcher
// ----------------------------------------------------------------------------
// Writes pattern settings over the register port while the matcher is idle,
// streams byte items made mostly of embedded pattern occurrences and near misses
// in random blocks, and toggles the match receiver; match_checker does the checking.
// ----------------------------------------------------------------------------
module testbench;

  localparam int PATTERN_MAX = 32;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 128;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE      = 4;

  // register slots past the last real one, must be ignored
  localparam logic [wbpm_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [wbpm_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [wbpm_pkg::CFG_ADDR_W-1:0] paddr;
  logic [wbpm_pkg::CFG_DATA_W-1:0] pwdata;
  logic [wbpm_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;
  int                              errors;
  int                              outstanding;

  wbpm_in_if  in_ch ();
  wbpm_out_if out_ch ();

  // stimulus-side copy of the active pattern, used to embed occurrences
  logic [4*wbpm_pkg::CFG_DATA_W-1:0] cfg_pattern;
  logic [wbpm_pkg::REG_POS-1:0]      cfg_wild;
  int                                cfg_len;

  // idle percentages of both sides and the one long receiver hold-off
  int                      tx_idle_pct;
  int                      rx_idle_pct;
  logic                    hold_req;
  logic                    hold_done;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  wildcard_byte_pattern_matcher #(
    .PATTERN_MAX(PATTERN_MAX)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  match_checker #(
    .PATTERN_MAX(PATTERN_MAX)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // hard stop in case the matcher hangs
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [wbpm_pkg::ADDR_W-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[wbpm_pkg::ADDR_W-1:0];
  endfunction

  function automatic logic [4*wbpm_pkg::CFG_DATA_W-1:0] rand_pattern();
    logic [4*wbpm_pkg::CFG_DATA_W-1:0] r;
    int                                i;
    for (i = 0; i < 8; i++) r[i*32 +: 32] = $urandom;
    return r;
  endfunction

  // setup, then access, then a return to idle so writes never overlap
  task automatic write_reg(input logic [wbpm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wbpm_pkg::CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // junk in the unused upper bits checks that the register widths mask them
  task automatic set_config(input logic [wbpm_pkg::LEN_W-1:0] len_raw,
                            input logic [4*wbpm_pkg::CFG_DATA_W-1:0] pattern,
                            input logic [wbpm_pkg::REG_POS-1:0] wild);
    write_reg(wbpm_pkg::REG_PAT_0, pattern[0*wbpm_pkg::CFG_DATA_W +: wbpm_pkg::CFG_DATA_W]);
    write_reg(wbpm_pkg::REG_PAT_1, pattern[1*wbpm_pkg::CFG_DATA_W +: wbpm_pkg::CFG_DATA_W]);
    write_reg(wbpm_pkg::REG_PAT_2, pattern[2*wbpm_pkg::CFG_DATA_W +: wbpm_pkg::CFG_DATA_W]);
    write_reg(wbpm_pkg::REG_PAT_3, pattern[3*wbpm_pkg::CFG_DATA_W +: wbpm_pkg::CFG_DATA_W]);
    write_reg(wbpm_pkg::REG_WILD, {$urandom, wild});
    write_reg(wbpm_pkg::REG_LEN, {$urandom, 26'($urandom), len_raw});
    cfg_pattern = pattern;
    cfg_wild    = wild;
    cfg_len     = (len_raw == 0) ? 1 : int'(len_raw);
    if (cfg_len > PATTERN_MAX) cfg_len = PATTERN_MAX;
    if (cfg_len > wbpm_pkg::REG_POS) cfg_len = wbpm_pkg::REG_POS;
  endtask

  // offer one byte item, with random idle cycles ahead of it
  task automatic send_item(input logic [wbpm_pkg::BYTE_W-1:0] data,
                           input logic [wbpm_pkg::ADDR_W-1:0] addr,
                           input logic start);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= wbpm_pkg::BYTE_W'($urandom);
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= data;
    in_ch.byte_address <= addr;
    in_ch.block_start  <= start;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering, let every expected match come out, then settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // random blocks; most items belong to embedded pattern occurrences or
  // near misses built from pattern bytes, the rest is plain noise
  task automatic run_phase(input int n_items);
    logic [wbpm_pkg::ADDR_W-1:0] addr;
    logic [wbpm_pkg::BYTE_W-1:0] data;
    logic                        start;
    int                          embed_pos;
    int                          i;
    embed_pos = -1;
    addr      = '0;
    for (i = 0; i < n_items; i++) begin
      start = (i == 0) || ($urandom_range(99) < 4);
      if (start) begin
        embed_pos = -1;
        // some blocks sit right below the top of the address space
        if ($urandom_range(3) == 0) addr = '1 - wbpm_pkg::ADDR_W'($urandom_range(40));
        else addr = rand_addr();
      end else if ($urandom_range(99) < 3) begin
        addr = rand_addr();
      end else begin
        addr = addr + 1'b1;
      end
      if (embed_pos < 0 && $urandom_range(99) < 8) embed_pos = 0;
      if (embed_pos >= 0) begin
        data = cfg_wild[embed_pos] ? wbpm_pkg::BYTE_W'($urandom)
                                   : cfg_pattern[embed_pos*wbpm_pkg::BYTE_W +: wbpm_pkg::BYTE_W];
        embed_pos++;
        if (embed_pos == cfg_len) embed_pos = -1;
      end else if ($urandom_range(1) == 1) begin
        data = cfg_pattern[$urandom_range(cfg_len - 1)*wbpm_pkg::BYTE_W +: wbpm_pkg::BYTE_W];
      end else begin
        data = wbpm_pkg::BYTE_W'($urandom);
      end
      send_item(data, addr, start);
    end
  endtask

  // match receiver: random stalls, plus one long hold-off counted here
  initial begin : receiver
    int n;
    out_ch.ready <= 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin : stimulus
    int ph;
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.data_byte    <= '0;
    in_ch.byte_address <= '0;
    in_ch.block_start  <= 1'b0;
    hold_req           <= 1'b0;
    rx_idle_pct        <= 76;
    tx_idle_pct = 33;
    cfg_pattern = '0;
    cfg_wild    = '0;
    cfg_len     = 1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: one position, byte zero; top address on its own
    send_item(8'h00, 48'h0, 1'b1);
    send_item(8'hFF, 48'hFFFF_FFFF_FFFF, 1'b0);
    send_item(8'h00, 48'hFFFF_FFFF_FFFF, 1'b0);
    wait_idle();

    // writes past the last register must change nothing
    write_reg(REG_SPARE_LO, {$urandom, $urandom});
    write_reg(REG_SPARE_HI, {$urandom, $urandom});

    // three positions, last one a wildcard
    set_config(6'd3, 256'h77_FF_00, 32'h4);
    send_item(8'h00, 48'h0, 1'b1);         // short block, nothing yet
    send_item(8'hFF, 48'h1, 1'b0);
    send_item(8'h5A, 48'h2, 1'b0);         // hit at 0
    send_item(8'h00, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_item(8'hFF, 48'h0, 1'b0);         // address wraps inside the block
    send_item(8'h12, 48'h1, 1'b0);         // start address wraps below zero
    send_item(8'h00, 48'h10, 1'b1);
    send_item(8'hFF, 48'h11, 1'b1);        // block start breaks the occurrence
    send_item(8'h33, 48'h12, 1'b0);
    wait_idle();

    // overlapping occurrences
    set_config(6'd2, 256'h11_11, 32'h0);
    send_item(8'h11, 48'h20, 1'b1);
    send_item(8'h11, 48'h21, 1'b0);
    send_item(8'h11, 48'h22, 1'b0);
    wait_idle();

    // zero length acts as one
    set_config(6'd0, 256'hAB, 32'h0);
    send_item(8'hAB, 48'h30, 1'b1);
    send_item(8'hAC, 48'h31, 1'b0);
    wait_idle();

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph < 3) begin
        tx_idle_pct = 33;
        rx_idle_pct <= 76;
      end else if (ph < 6) begin
        tx_idle_pct = 76;
        rx_idle_pct <= 33;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      unique case (ph)
        0: set_config(6'd1, rand_pattern(), 32'h0);
        1: set_config(6'd32, '1, 32'h0);
        2: set_config(6'd63, rand_pattern(), $urandom);   // clamps to the maximum
        3: set_config(6'd0, '0, 32'h0);
        6: begin
          // every byte matches, so the held receiver backs up the input
          set_config(6'd1, rand_pattern(), '1);
          hold_req <= 1'b1;
        end
        default: set_config(wbpm_pkg::LEN_W'($urandom_range(2, (ph == 8) ? 31 : 10)),
                            rand_pattern(), $urandom & $urandom);
      endcase
      run_phase(PHASE_ITEMS);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/wbpm_pkg.sv
src/wbpm_if.sv
src/wbpm_cell.sv
src/wbpm_out_buf.sv
src/wildcard_byte_pattern_matcher.sv
tb/match_checker.sv
tb/testbench.sv
